/* rtl/gscs_pkg.sv */
`default_nettype none

package gscs_pkg;

    localparam int MAX_VERTICES_DEF  = 4096;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int SUM_W     = 48;
    localparam int TERM_W    = 62;
    localparam int CAP_EXP   = 60;
    localparam int VCOUNT_W  = 13;
    localparam int TWEIGHT_W = 40;
    localparam int INDEX_W   = 12;
    localparam int WEIGHT_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 40;
    localparam int MASK_W    = 5;

    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_WEIGHT = 2'd1;

    localparam logic [VCOUNT_W-1:0]  VERTEX_COUNT_RST = 13'd4096;
    localparam logic [SUM_W-1:0]     SAT_MAX = {1'b0, {(SUM_W-1){1'b1}}};

    typedef enum logic [2:0] {
        TERM_C_A     = 3'd0,
        TERM_C_B     = 3'd1,
        TERM_AA_SA   = 3'd2,
        TERM_BB_SB   = 3'd3,
        TERM_C_SA    = 3'd4,
        TERM_C_SB    = 3'd5,
        TERM_C_MINAB = 3'd6,
        TERM_C_MINS  = 3'd7
    } term_sel_t;

    typedef struct packed {
        logic      clear_init;
        logic      clear;
        logic      edge_load;
        logic      accum;
        logic      update;
        logic      div_start;
        logic      term_store;
        term_sel_t term_sel;
        logic      out_load;
    } gscs_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic last_edge;
        logic div_done;
    } gscs_status_t;

    function automatic logic [SUM_W-1:0] sat48(input logic signed [TERM_W:0] v);
        logic [SUM_W-1:0] r;
        if (v > $signed({{(TERM_W-SUM_W+1){1'b0}}, SAT_MAX}))
            r = SAT_MAX;
        else if (v < $signed({{(TERM_W-SUM_W+1){1'b1}}, ~SAT_MAX}))
            r = ~SAT_MAX;
        else
            r = v[SUM_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/gscs_div.sv */
`default_nettype none

module gscs_div #(
    parameter int FRACTION_BITS = gscs_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [gscs_pkg::SUM_W-1:0] num,
    input  wire logic signed [gscs_pkg::SUM_W-1:0] den,
    output logic                                   done,
    output logic signed [gscs_pkg::TERM_W-1:0]     term
);

    localparam int SW = gscs_pkg::SUM_W;
    localparam int NW = SW + FRACTION_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam int QW = (NW > gscs_pkg::CAP_EXP + 1) ? NW : gscs_pkg::CAP_EXP + 1;
    localparam logic [QW-1:0] CAP_Q = QW'(1) << gscs_pkg::CAP_EXP;

    logic [NW-1:0] quo_reg, quo_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] md_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [SW:0]   trial;
    logic          fits;
    logic [SW-1:0] mn, md;
    logic [QW-1:0] q_ext;
    logic [gscs_pkg::CAP_EXP:0] mag;

    assign mn = num[SW-1] ? (~num + SW'(1)) : num;
    assign md = den[SW-1] ? (~den + SW'(1)) : den;

    assign trial    = {rem_reg, quo_reg[NW-1]};
    assign fits     = trial >= {1'b0, md_reg};
    assign rem_next = fits ? SW'(trial - {1'b0, md_reg}) : trial[SW-1:0];
    assign quo_next = {quo_reg[NW-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= {mn, {FRACTION_BITS{1'b0}}};
            rem_reg <= '0;
            md_reg  <= md;
            neg_reg <= num[SW-1] ^ den[SW-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // clamp magnitude at 2^60, then apply sign
    assign q_ext = QW'(quo_reg);
    assign mag   = (q_ext >= CAP_Q) ? CAP_Q[gscs_pkg::CAP_EXP:0] : q_ext[gscs_pkg::CAP_EXP:0];
    assign term  = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign done  = done_reg;

endmodule

`default_nettype wire

/* rtl/gscs_datapath.sv */
`default_nettype none

module gscs_datapath #(
    parameter int MAX_VERTICES  = gscs_pkg::MAX_VERTICES_DEF,
    parameter int FRACTION_BITS = gscs_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire gscs_pkg::gscs_cmd_t                cmd,
    output gscs_pkg::gscs_status_t                  status,
    input  wire logic                               cfg_we,
    input  wire logic [gscs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gscs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [gscs_pkg::INDEX_W-1:0]       vertex,
    input  wire logic [gscs_pkg::INDEX_W-1:0]       neighbor,
    input  wire logic [gscs_pkg::WEIGHT_W-1:0]      weight,
    input  wire logic                               has_edge,
    input  wire logic                               last_edge,
    output logic [gscs_pkg::SUM_W-1:0]              normalized_cut,
    output logic [gscs_pkg::SUM_W-1:0]              average_association,
    output logic [gscs_pkg::SUM_W-1:0]              average_cut,
    output logic [gscs_pkg::SUM_W-1:0]              quotient_cut,
    output logic [gscs_pkg::SUM_W-1:0]              size_ratio_cut,
    output logic [gscs_pkg::SUM_W-1:0]              cut_value,
    output logic [gscs_pkg::SUM_W-1:0]              association_a,
    output logic [gscs_pkg::INDEX_W-1:0]            sweep_position,
    output logic [gscs_pkg::MASK_W-1:0]             zero_denominator_mask
);

    localparam int SW = gscs_pkg::SUM_W;
    localparam int TW = gscs_pkg::TERM_W;
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic [gscs_pkg::VCOUNT_W-1:0]  vertex_count_reg;
    logic [gscs_pkg::TWEIGHT_W-1:0] total_weight_reg;

    logic mem_bits [MAX_VERTICES];
    logic rd_bit_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic [gscs_pkg::INDEX_W-1:0]  vertex_reg;
    logic [gscs_pkg::WEIGHT_W-1:0] weight_reg;
    logic has_reg, last_reg, nb_ok_reg;

    logic [SW-1:0] cut_reg, assoc_a_reg, assoc_b_reg, assoc_aa_reg, assoc_bb_reg;
    logic [SW-1:0] ea_reg, eb_reg, deg_reg;
    logic [gscs_pkg::INDEX_W-1:0] step_reg;

    logic signed [TW-1:0] first_reg;
    logic [SW-1:0]        score_reg [gscs_pkg::MASK_W];

    logic                 wr_en, wr_data;
    logic [AW-1:0]        wr_addr;
    logic [SW-1:0]        w48;
    logic [12:0]          sa;
    logic signed [13:0]   sb;
    logic signed [SW-1:0] a_s, b_s, sa_s, sb_s, min_ab, min_s;
    logic signed [SW-1:0] div_num, div_den;
    logic                 div_done;
    logic signed [TW-1:0] term;
    logic signed [TW:0]   pair_sum;
    logic [gscs_pkg::MASK_W-1:0] mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= gscs_pkg::VERTEX_COUNT_RST;
            total_weight_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == gscs_pkg::CFG_VERTEX_COUNT)
                vertex_count_reg <= cfg_data[gscs_pkg::VCOUNT_W-1:0];
            else if (cfg_index == gscs_pkg::CFG_TOTAL_WEIGHT)
                total_weight_reg <= cfg_data[gscs_pkg::TWEIGHT_W-1:0];
        end
    end

    // membership bitmap: clearing sweep or mark on vertex close
    assign wr_en   = cmd.clear || (cmd.update && (32'(vertex_reg) < MAX_VERTICES));
    assign wr_addr = cmd.clear ? clr_cnt_reg : AW'(vertex_reg);
    assign wr_data = !cmd.clear;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_bits[wr_addr] <= wr_data;
        if (cmd.edge_load)
            rd_bit_reg <= mem_bits[AW'(neighbor)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clear_init)
            clr_cnt_reg <= '0;
        else if (cmd.clear)
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.edge_load)
        begin
            vertex_reg <= vertex;
            weight_reg <= weight;
            has_reg    <= has_edge;
            last_reg   <= last_edge;
            nb_ok_reg  <= 32'(neighbor) < MAX_VERTICES;
        end
    end

    assign w48 = SW'(weight_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_reg      <= '0;
            assoc_a_reg  <= '0;
            assoc_b_reg  <= '0;
            assoc_aa_reg <= '0;
            assoc_bb_reg <= '0;
            ea_reg       <= '0;
            eb_reg       <= '0;
            deg_reg      <= '0;
            step_reg     <= '0;
        end
        else if (cmd.clear)
        begin
            cut_reg      <= '0;
            assoc_a_reg  <= '0;
            assoc_b_reg  <= SW'(total_weight_reg);
            assoc_aa_reg <= '0;
            assoc_bb_reg <= SW'(total_weight_reg);
            ea_reg       <= '0;
            eb_reg       <= '0;
            deg_reg      <= '0;
            step_reg     <= '0;
        end
        else if (cmd.accum)
        begin
            if (has_reg)
            begin
                deg_reg <= deg_reg + w48;
                if (nb_ok_reg && rd_bit_reg)
                    ea_reg <= ea_reg + w48;
                else
                    eb_reg <= eb_reg + w48;
            end
        end
        else if (cmd.update)
        begin
            cut_reg      <= cut_reg - ea_reg + eb_reg;
            assoc_a_reg  <= assoc_a_reg + deg_reg;
            assoc_b_reg  <= assoc_b_reg - deg_reg;
            assoc_aa_reg <= assoc_aa_reg + {ea_reg[SW-2:0], 1'b0};
            assoc_bb_reg <= assoc_bb_reg - {eb_reg[SW-2:0], 1'b0};
            ea_reg       <= '0;
            eb_reg       <= '0;
            deg_reg      <= '0;
        end
        else if (cmd.out_load)
        begin
            step_reg <= step_reg + gscs_pkg::INDEX_W'(1);
        end
    end

    // set sizes |A| and |B|
    assign sa     = {1'b0, step_reg} + 13'd1;
    assign sb     = $signed({1'b0, vertex_count_reg}) - $signed({2'b0, step_reg}) - 14'sd1;
    assign a_s    = $signed(assoc_a_reg);
    assign b_s    = $signed(assoc_b_reg);
    assign sa_s   = $signed({{(SW-13){1'b0}}, sa});
    assign sb_s   = $signed({{(SW-14){sb[13]}}, sb});
    assign min_ab = (a_s < b_s) ? a_s : b_s;
    assign min_s  = (sa_s < sb_s) ? sa_s : sb_s;

    always_comb
    begin
        div_num = $signed(cut_reg);
        div_den = a_s;
        case (cmd.term_sel)
            gscs_pkg::TERM_C_A:     div_den = a_s;
            gscs_pkg::TERM_C_B:     div_den = b_s;
            gscs_pkg::TERM_AA_SA:
            begin
                div_num = $signed(assoc_aa_reg);
                div_den = sa_s;
            end
            gscs_pkg::TERM_BB_SB:
            begin
                div_num = $signed(assoc_bb_reg);
                div_den = sb_s;
            end
            gscs_pkg::TERM_C_SA:    div_den = sa_s;
            gscs_pkg::TERM_C_SB:    div_den = sb_s;
            gscs_pkg::TERM_C_MINAB: div_den = min_ab;
            gscs_pkg::TERM_C_MINS:  div_den = min_s;
            default:                div_den = a_s;
        endcase
    end

    gscs_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .term  (term)
    );

    assign pair_sum = {first_reg[TW-1], first_reg} + {term[TW-1], term};

    always_ff @(posedge clk)
    begin
        if (cmd.term_store)
        begin
            case (cmd.term_sel)
                gscs_pkg::TERM_C_A,
                gscs_pkg::TERM_AA_SA,
                gscs_pkg::TERM_C_SA:    first_reg <= term;
                gscs_pkg::TERM_C_B:     score_reg[0] <= gscs_pkg::sat48(pair_sum);
                gscs_pkg::TERM_BB_SB:   score_reg[1] <= gscs_pkg::sat48(pair_sum);
                gscs_pkg::TERM_C_SB:    score_reg[2] <= gscs_pkg::sat48(pair_sum);
                gscs_pkg::TERM_C_MINAB: score_reg[3] <= gscs_pkg::sat48({term[TW-1], term});
                gscs_pkg::TERM_C_MINS:  score_reg[4] <= gscs_pkg::sat48({term[TW-1], term});
                default:                first_reg <= term;
            endcase
        end
    end

    assign mask[0] = (assoc_a_reg == '0) || (assoc_b_reg == '0);
    assign mask[1] = (sb == 14'sd0);
    assign mask[2] = (sb == 14'sd0);
    assign mask[3] = (min_ab == '0);
    assign mask[4] = (min_s == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            normalized_cut        <= mask[0] ? gscs_pkg::SAT_MAX : score_reg[0];
            average_association   <= mask[1] ? gscs_pkg::SAT_MAX : score_reg[1];
            average_cut           <= mask[2] ? gscs_pkg::SAT_MAX : score_reg[2];
            quotient_cut          <= mask[3] ? gscs_pkg::SAT_MAX : score_reg[3];
            size_ratio_cut        <= mask[4] ? gscs_pkg::SAT_MAX : score_reg[4];
            cut_value             <= cut_reg;
            association_a         <= assoc_a_reg;
            sweep_position        <= step_reg;
            zero_denominator_mask <= mask;
        end
    end

    assign status.clear_done = (clr_cnt_reg == AW'(MAX_VERTICES - 1));
    assign status.last_edge  = last_reg;
    assign status.div_done   = div_done;

endmodule

`default_nettype wire

/* rtl/gscs_ctrl.sv */
`default_nettype none

module gscs_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   op,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire logic                   cfg_restart,
    input  wire gscs_pkg::gscs_status_t status,
    output gscs_pkg::gscs_cmd_t         cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_ACC      = 7'b0000100,
        ST_UPDATE   = 7'b0001000,
        ST_DIV_GO   = 7'b0010000,
        ST_DIV_WAIT = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    gscs_pkg::term_sel_t   sel_reg, sel_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  accept, out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.term_sel   = sel_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.edge_load = 1'b1;
                    if (op == gscs_pkg::OP_RESTART)
                    begin
                        cmd.clear_init = 1'b1;
                        state_next     = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_ACC;
                    end
                end
            end
            ST_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = status.last_edge ? ST_UPDATE : ST_IDLE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                sel_next   = gscs_pkg::TERM_C_A;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.term_store = 1'b1;
                    if (sel_reg == gscs_pkg::TERM_C_MINS)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        sel_next   = gscs_pkg::term_sel_t'(sel_reg + 3'd1);
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_FINISH:
            begin
                // hold until the output register frees up
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_restart)
        begin
            cmd            = '0;
            cmd.term_sel   = sel_reg;
            cmd.clear_init = 1'b1;
            state_next     = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sel_reg       <= gscs_pkg::TERM_C_A;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside wait state");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output register overwritten");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == gscs_pkg::OP_RESTART) |=> state_reg == ST_CLEAR)
        else $error("restart request did not start clearing");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_WAIT || state_reg == ST_CLEAR) |-> !in_ready)
        else $error("request taken while busy");

endmodule

`default_nettype wire

/* rtl/graph_sweep_cut_scorer.sv */
// Edge request without last_edge: ST_ACC is passed before the next request can be taken.
// Last edge: ST_ACC and ST_UPDATE, then ST_DIV_GO and ST_DIV_WAIT for each of eight
//   quotients run one after another through one bit-serial divider, one bit a cycle;
//   then ST_FINISH loads the result once the output register is free.
// A finished result waits in an output register; edge requests keep flowing meanwhile.
// After reset, a restart request or a write to either configuration register, the bitmap
//   is swept clear over all MAX_VERTICES entries while no request is taken.
`default_nettype none

module graph_sweep_cut_scorer #(
    parameter int MAX_VERTICES  = gscs_pkg::MAX_VERTICES_DEF,
    parameter int FRACTION_BITS = gscs_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [gscs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gscs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            op,
    input  wire logic [gscs_pkg::INDEX_W-1:0]    vertex,
    input  wire logic [gscs_pkg::INDEX_W-1:0]    neighbor,
    input  wire logic [gscs_pkg::WEIGHT_W-1:0]   weight,
    input  wire logic                            has_edge,
    input  wire logic                            last_edge,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [gscs_pkg::SUM_W-1:0]           normalized_cut,
    output logic [gscs_pkg::SUM_W-1:0]           average_association,
    output logic [gscs_pkg::SUM_W-1:0]           average_cut,
    output logic [gscs_pkg::SUM_W-1:0]           quotient_cut,
    output logic [gscs_pkg::SUM_W-1:0]           size_ratio_cut,
    output logic [gscs_pkg::SUM_W-1:0]           cut_value,
    output logic [gscs_pkg::SUM_W-1:0]           association_a,
    output logic [gscs_pkg::INDEX_W-1:0]         sweep_position,
    output logic [gscs_pkg::MASK_W-1:0]          zero_denominator_mask
);

    gscs_pkg::gscs_cmd_t    cmd;
    gscs_pkg::gscs_status_t status;
    logic                   cfg_restart;

    assign cfg_restart = cfg_we && ((cfg_index == gscs_pkg::CFG_VERTEX_COUNT) ||
                                    (cfg_index == gscs_pkg::CFG_TOTAL_WEIGHT));

    gscs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .op          (op),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cfg_restart (cfg_restart),
        .status      (status),
        .cmd         (cmd)
    );

    gscs_datapath #(
        .MAX_VERTICES  (MAX_VERTICES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .status                (status),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .vertex                (vertex),
        .neighbor              (neighbor),
        .weight                (weight),
        .has_edge              (has_edge),
        .last_edge             (last_edge),
        .normalized_cut        (normalized_cut),
        .average_association   (average_association),
        .average_cut           (average_cut),
        .quotient_cut          (quotient_cut),
        .size_ratio_cut        (size_ratio_cut),
        .cut_value             (cut_value),
        .association_a         (association_a),
        .sweep_position        (sweep_position),
        .zero_denominator_mask (zero_denominator_mask)
    );

endmodule

`default_nettype wire

/* verif/graph_sweep_cut_scorer_tb.sv */
`default_nettype none

module graph_sweep_cut_scorer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_W            = gscs_pkg::SUM_W;
    localparam int INDEX_W          = gscs_pkg::INDEX_W;
    localparam int WEIGHT_W         = gscs_pkg::WEIGHT_W;
    localparam int MASK_W           = gscs_pkg::MASK_W;
    localparam int CFG_IDX_W        = gscs_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W       = gscs_pkg::CFG_DATA_W;
    localparam int VCOUNT_W         = gscs_pkg::VCOUNT_W;
    localparam int TWEIGHT_W        = gscs_pkg::TWEIGHT_W;
    localparam int CAP_EXP          = gscs_pkg::CAP_EXP;
    localparam int MAX_VERTICES_DEF = gscs_pkg::MAX_VERTICES_DEF;
    localparam logic OP_EDGE        = gscs_pkg::OP_EDGE;
    localparam logic OP_RESTART     = gscs_pkg::OP_RESTART;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = gscs_pkg::CFG_VERTEX_COUNT;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_WEIGHT = gscs_pkg::CFG_TOTAL_WEIGHT;
    localparam logic [VCOUNT_W-1:0]  VERTEX_COUNT_RST = gscs_pkg::VERTEX_COUNT_RST;
    localparam logic [SUM_W-1:0]     SAT_MAX          = gscs_pkg::SAT_MAX;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  CLEAR_WAIT  = 4200;
    localparam int  LONG_HOLD   = 3000;
    localparam int  FB          = gscs_pkg::FRACTION_BITS_DEF;

    typedef struct packed {
        logic                op;
        logic [INDEX_W-1:0]  vertex;
        logic [INDEX_W-1:0]  neighbor;
        logic [WEIGHT_W-1:0] weight;
        logic                has_edge;
        logic                last_edge;
    } sweep_req_t;

    typedef struct packed {
        logic [SUM_W-1:0]   ncut;
        logic [SUM_W-1:0]   avg_assoc;
        logic [SUM_W-1:0]   avg_cut;
        logic [SUM_W-1:0]   qcut;
        logic [SUM_W-1:0]   size_cut;
        logic [SUM_W-1:0]   cut;
        logic [SUM_W-1:0]   assoc_a;
        logic [INDEX_W-1:0] pos;
        logic [MASK_W-1:0]  zmask;
    } sweep_score_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic op = 1'b0;
    logic [INDEX_W-1:0] vertex = '0;
    logic [INDEX_W-1:0] neighbor = '0;
    logic [WEIGHT_W-1:0] weight = '0;
    logic has_edge = 1'b0;
    logic last_edge = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [SUM_W-1:0] normalized_cut, average_association, average_cut;
    logic [SUM_W-1:0] quotient_cut, size_ratio_cut, cut_value, association_a;
    logic [INDEX_W-1:0] sweep_position;
    logic [MASK_W-1:0] zero_denominator_mask;

    graph_sweep_cut_scorer i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .vertex(vertex), .neighbor(neighbor), .weight(weight),
        .has_edge(has_edge), .last_edge(last_edge),
        .out_valid(out_valid), .out_ready(out_ready),
        .normalized_cut(normalized_cut), .average_association(average_association),
        .average_cut(average_cut), .quotient_cut(quotient_cut),
        .size_ratio_cut(size_ratio_cut), .cut_value(cut_value),
        .association_a(association_a), .sweep_position(sweep_position),
        .zero_denominator_mask(zero_denominator_mask)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // sweep state mirror
    logic                 member_a [MAX_VERTICES_DEF];
    logic [SUM_W-1:0]     cut_acc, assoc_a_acc, assoc_b_acc, assoc_aa_acc, assoc_bb_acc;
    logic [SUM_W-1:0]     to_a_acc, to_b_acc, degree_acc;
    logic [INDEX_W-1:0]   step_idx;
    logic [VCOUNT_W-1:0]  n_vertices = VERTEX_COUNT_RST;
    logic [TWEIGHT_W-1:0] total_w = '0;

    sweep_req_t   req_q[$];
    sweep_score_t score_q[$];
    int           errors = 0;
    int           scores_seen = 0;
    bit           no_idle = 1'b0;

    function automatic longint sext48(logic [SUM_W-1:0] x);
        longint r;
        r = {{(64-SUM_W){x[SUM_W-1]}}, x};
        return r;
    endfunction

    function automatic longint clamp48(longint v);
        longint hi;
        hi = (64'sd1 <<< 47) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // truncated (num << FB) / den, magnitude capped at 2^60
    function automatic longint scaled_quot(longint num, longint den);
        logic [63:0]  mn, md, mag;
        logic [127:0] wide;
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        if (mn / md >= (64'd1 << (CAP_EXP - FB)))
            mag = 64'd1 << CAP_EXP;
        else
        begin
            wide = {64'd0, mn} << FB;
            wide = wide / {64'd0, md};
            mag  = wide[63:0];
        end
        return ((num < 0) != (den < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic void clear_sweep();
        foreach (member_a[i])
            member_a[i] = 1'b0;
        cut_acc      = '0;
        assoc_a_acc  = '0;
        assoc_b_acc  = SUM_W'(total_w);
        assoc_aa_acc = '0;
        assoc_bb_acc = SUM_W'(total_w);
        to_a_acc     = '0;
        to_b_acc     = '0;
        degree_acc   = '0;
        step_idx     = '0;
    endfunction

    function automatic void score_request(sweep_req_t r);
        longint       c, a, b, aa, bb, sa, sb, m;
        sweep_score_t s;
        if (r.op == OP_RESTART)
        begin
            clear_sweep();
            return;
        end
        if (r.has_edge)
        begin
            degree_acc = degree_acc + r.weight;
            if (member_a[r.neighbor])
                to_a_acc = to_a_acc + r.weight;
            else
                to_b_acc = to_b_acc + r.weight;
        end
        if (!r.last_edge)
            return;
        cut_acc      = cut_acc - to_a_acc + to_b_acc;
        assoc_a_acc  = assoc_a_acc + degree_acc;
        assoc_b_acc  = assoc_b_acc - degree_acc;
        assoc_aa_acc = assoc_aa_acc + (to_a_acc << 1);
        assoc_bb_acc = assoc_bb_acc - (to_b_acc << 1);
        member_a[r.vertex] = 1'b1;
        c  = sext48(cut_acc);
        a  = sext48(assoc_a_acc);
        b  = sext48(assoc_b_acc);
        aa = sext48(assoc_aa_acc);
        bb = sext48(assoc_bb_acc);
        sa = longint'(step_idx) + 1;
        sb = longint'(n_vertices) - longint'(step_idx) - 1;
        s.zmask = '0;
        if (a == 0 || b == 0)
        begin
            s.zmask[0] = 1'b1;
            s.ncut = SAT_MAX;
        end
        else
            s.ncut = SUM_W'(clamp48(scaled_quot(c, a) + scaled_quot(c, b)));
        if (sb == 0)
        begin
            s.zmask[2:1] = 2'b11;
            s.avg_assoc = SAT_MAX;
            s.avg_cut   = SAT_MAX;
        end
        else
        begin
            s.avg_assoc = SUM_W'(clamp48(scaled_quot(aa, sa) + scaled_quot(bb, sb)));
            s.avg_cut   = SUM_W'(clamp48(scaled_quot(c, sa) + scaled_quot(c, sb)));
        end
        m = (a < b) ? a : b;
        if (m == 0)
        begin
            s.zmask[3] = 1'b1;
            s.qcut = SAT_MAX;
        end
        else
            s.qcut = SUM_W'(clamp48(scaled_quot(c, m)));
        m = (sa < sb) ? sa : sb;
        if (m == 0)
        begin
            s.zmask[4] = 1'b1;
            s.size_cut = SAT_MAX;
        end
        else
            s.size_cut = SUM_W'(clamp48(scaled_quot(c, m)));
        s.cut     = cut_acc;
        s.assoc_a = assoc_a_acc;
        s.pos     = step_idx;
        score_q.push_back(s);
        step_idx   = step_idx + 1'b1;
        to_a_acc   = '0;
        to_b_acc   = '0;
        degree_acc = '0;
    endfunction

    // driver
    sweep_req_t cur_req;
    int         send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic holding, nv;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            holding = in_valid && !in_ready;
            if (in_valid && in_ready)
                score_request(cur_req);
            nv = holding;
            if (!holding)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (req_q.size() > 0)
                begin
                    cur_req = req_q.pop_front();
                    nv = 1'b1;
                    send_gap = no_idle ? 0 : $urandom_range(0, 5);
                    op        <= cur_req.op;
                    vertex    <= cur_req.vertex;
                    neighbor  <= cur_req.neighbor;
                    weight    <= cur_req.weight;
                    has_edge  <= cur_req.has_edge;
                    last_edge <= cur_req.last_edge;
                end
            end
            in_valid <= nv;
        end
    end

    // monitor
    int  recv_stall = 0;
    int  hold_cnt = 0;
    bit  held = 1'b0;

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sweep_score_t s;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                scores_seen++;
                if (score_q.size() == 0)
                begin
                    $error("unexpected score at position %0d", sweep_position);
                    errors++;
                end
                else
                begin
                    s = score_q.pop_front();
                    check_field("normalized_cut", s.ncut, normalized_cut);
                    check_field("average_association", s.avg_assoc, average_association);
                    check_field("average_cut", s.avg_cut, average_cut);
                    check_field("quotient_cut", s.qcut, quotient_cut);
                    check_field("size_ratio_cut", s.size_cut, size_ratio_cut);
                    check_field("cut_value", s.cut, cut_value);
                    check_field("association_a", s.assoc_a, association_a);
                    check_field("sweep_position", s.pos, sweep_position);
                    check_field("zero_denominator_mask", s.zmask, zero_denominator_mask);
                end
                recv_stall = no_idle ? 0 : $urandom_range(0, 5);
                if (scores_seen == 25 && !held)
                begin
                    held = 1'b1;
                    hold_cnt = LONG_HOLD;
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    int cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_VERTEX_COUNT)
            n_vertices = data[VCOUNT_W-1:0];
        else
            total_w = data[TWEIGHT_W-1:0];
        clear_sweep();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || in_valid || score_q.size() != 0)
            @(posedge clk);
        repeat (CLEAR_WAIT) @(posedge clk);
    endtask

    function automatic sweep_req_t make_req(logic o, logic [INDEX_W-1:0] v,
                                            logic [INDEX_W-1:0] nb, logic [WEIGHT_W-1:0] w,
                                            logic h, logic l);
        sweep_req_t r;
        r.op = o; r.vertex = v; r.neighbor = nb; r.weight = w;
        r.has_edge = h; r.last_edge = l;
        return r;
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return '1;
        if (p < 15)
            return '0;
        return WEIGHT_W'($urandom);
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        return ($urandom_range(0, 4) == 0) ? INDEX_W'($urandom) : INDEX_W'($urandom_range(0, 15));
    endfunction

    // groups of one vertex worth of edges each, with stray edges and restarts now and then
    task automatic queue_random(int count);
        int n, p, k;
        logic [INDEX_W-1:0] v;
        n = 0;
        while (n < count)
        begin
            p = $urandom_range(0, 199);
            if (p < 2)
            begin
                req_q.push_back(make_req(OP_RESTART, INDEX_W'($urandom), INDEX_W'($urandom),
                                         WEIGHT_W'($urandom), 1'($urandom), 1'($urandom)));
                n++;
            end
            else if (p < 14)
            begin
                req_q.push_back(make_req(OP_EDGE, INDEX_W'($urandom), pick_index(),
                                         pick_weight(), 1'($urandom), 1'b0));
                n++;
            end
            else
            begin
                v = pick_index();
                k = $urandom_range(0, 4);
                if (k == 0)
                    req_q.push_back(make_req(OP_EDGE, v, INDEX_W'($urandom),
                                             WEIGHT_W'($urandom), 1'b0, 1'b1));
                for (int e = 0; e < k; e++)
                    req_q.push_back(make_req(OP_EDGE, v, pick_index(), pick_weight(),
                                             1'b1, e == k - 1));
                n += (k == 0) ? 1 : k;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        clear_sweep();

        cfg_write(CFG_VERTEX_COUNT, 40'd6);
        cfg_write(CFG_TOTAL_WEIGHT, 40'd400000);
        // directed: extremes, vertex without edges, edge into A, restart
        req_q.push_back(make_req(OP_EDGE, 12'd0, 12'd4095, 16'hFFFF, 1'b1, 1'b0));
        req_q.push_back(make_req(OP_EDGE, 12'd0, 12'd1, 16'd0, 1'b1, 1'b1));
        req_q.push_back(make_req(OP_EDGE, 12'd1, 12'd0, 16'hFFFF, 1'b1, 1'b1));
        req_q.push_back(make_req(OP_EDGE, 12'd4095, 12'd2, 16'd5, 1'b0, 1'b1));
        req_q.push_back(make_req(OP_EDGE, 12'd2, 12'd4095, 16'd7, 1'b0, 1'b0));
        req_q.push_back(make_req(OP_EDGE, 12'd2, 12'd4095, 16'd9, 1'b1, 1'b1));
        req_q.push_back(make_req(OP_EDGE, 12'd3, 12'd0, 16'd100, 1'b1, 1'b1));
        req_q.push_back(make_req(OP_EDGE, 12'd4, 12'd3, 16'd1, 1'b1, 1'b1));
        req_q.push_back(make_req(OP_EDGE, 12'd5, 12'd9, 16'd1, 1'b1, 1'b1));
        req_q.push_back(make_req(OP_EDGE, 12'd6, 12'd9, 16'd1, 1'b1, 1'b1));
        req_q.push_back(make_req(OP_RESTART, 12'hFFF, 12'hFFF, 16'hFFFF, 1'b1, 1'b1));
        req_q.push_back(make_req(OP_EDGE, 12'd7, 12'd8, 16'h8000, 1'b1, 1'b1));
        queue_random(300);
        wait_drained();

        no_idle = 1'b1;
        cfg_write(CFG_VERTEX_COUNT, 40'd1);
        cfg_write(CFG_TOTAL_WEIGHT, 40'hFF_FFFF_FFFF);
        queue_random(250);
        wait_drained();

        no_idle = 1'b0;
        cfg_write(CFG_VERTEX_COUNT, 40'd4096);
        cfg_write(CFG_TOTAL_WEIGHT, 40'd0);
        queue_random(250);
        wait_drained();

        cfg_write(CFG_VERTEX_COUNT, 40'd8191);
        cfg_write(CFG_TOTAL_WEIGHT, 40'($urandom_range(0, 2000000)));
        queue_random(250);
        wait_drained();

        cfg_write(CFG_TOTAL_WEIGHT, {8'($urandom), 32'($urandom)});
        cfg_write(CFG_VERTEX_COUNT, 40'($urandom_range(2, 20)));
        queue_random(450);
        while (req_q.size() != 0 || in_valid || score_q.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/gscs_pkg.sv
rtl/gscs_div.sv
rtl/gscs_datapath.sv
rtl/gscs_ctrl.sv
rtl/graph_sweep_cut_scorer.sv
verif/graph_sweep_cut_scorer_tb.sv
